/* design/dwd_pkg.sv */
// shared constants and types for the distance weighted drag unit
package dwd_pkg;

    // fixed field widths
    localparam int unsigned CoordW = 32;
    localparam int unsigned DistW  = 33;
    localparam int unsigned MagW   = 33;
    localparam int unsigned ProdW  = 2 * MagW;
    localparam int unsigned IndexW = 6;
    localparam int unsigned OpW    = 2;
    localparam int unsigned CfgIdxW = 2;

    // default store depth
    localparam int unsigned MaxPointsDefault = 64;

    // operation codes
    typedef enum logic [OpW-1:0] {
        OP_CLEAR = 2'd0,
        OP_LOAD  = 2'd1,
        OP_DRAG  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    // configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        CFG_FAR_MODE = 2'd0,
        CFG_ANCHOR_X = 2'd1,
        CFG_ANCHOR_Y = 2'd2,
        CFG_SPARE    = 2'd3
    } cfg_idx_t;

endpackage

/* design/dwd_mul.sv */
// sequential shift-add multiplier, one multiplier bit per cycle
module dwd_mul (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [dwd_pkg::MagW-1:0]  a,
    input  logic [dwd_pkg::MagW-1:0]  b,
    output logic                     done,
    output logic [dwd_pkg::ProdW-1:0] prod
);
    import dwd_pkg::*;

    localparam int unsigned CntW = $clog2(MagW + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CntW-1:0]   cnt_reg;
    logic [MagW-1:0]   a_reg;
    logic [ProdW-1:0]  p_reg;
    logic [MagW:0]     sum;

    // partial sum on the upper half
    assign sum = {1'b0, p_reg[ProdW-1:MagW]} + (p_reg[0] ? {1'b0, a_reg} : '0);

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CntW'(MagW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg <= a;
            p_reg <= {{MagW{1'b0}}, b};
        end else if (busy_reg) begin
            p_reg <= {sum, p_reg[MagW-1:1]};
        end
    end

    assign done = done_reg;
    assign prod = p_reg;

endmodule

/* design/dwd_sqrt.sv */
// digit-by-digit integer square root, two operand bits per cycle
module dwd_sqrt (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [dwd_pkg::ProdW-1:0] operand,
    output logic                     done,
    output logic [dwd_pkg::DistW-1:0] root
);
    import dwd_pkg::*;

    localparam int unsigned Steps = ProdW / 2;
    localparam int unsigned CntW  = $clog2(Steps + 1);
    localparam int unsigned RemW  = DistW + 4;

    logic              busy_reg;
    logic              done_reg;
    logic [CntW-1:0]   cnt_reg;
    logic [ProdW-1:0]  op_reg;
    logic [DistW-1:0]  root_reg;
    logic [RemW-1:0]   rem_reg;
    logic [RemW-1:0]   rem_sh;
    logic [RemW-1:0]   trial;
    logic              fits;

    // trial subtraction for the next root bit
    assign rem_sh = {rem_reg[RemW-3:0], op_reg[ProdW-1:ProdW-2]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign fits   = rem_sh >= trial;

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CntW'(Steps - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            op_reg   <= operand;
            root_reg <= '0;
            rem_reg  <= '0;
        end else if (busy_reg) begin
            op_reg   <= {op_reg[ProdW-3:0], 2'b00};
            root_reg <= {root_reg[DistW-2:0], fits};
            rem_reg  <= fits ? rem_sh - trial : rem_sh;
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

/* design/dwd_div.sv */
// restoring divider, one quotient bit per cycle; quotient known to fit below 2^33
module dwd_div (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [dwd_pkg::ProdW-1:0] num,
    input  logic [dwd_pkg::DistW-1:0] den,
    output logic                     done,
    output logic [dwd_pkg::MagW-1:0]  quot
);
    import dwd_pkg::*;

    localparam int unsigned Steps = ProdW - DistW + 1;
    localparam int unsigned CntW  = $clog2(Steps + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CntW-1:0]   cnt_reg;
    logic [DistW-1:0]  den_reg;
    logic [DistW-1:0]  rem_reg;
    logic [Steps-1:0]  sh_reg;
    logic [DistW:0]    rem_sh;
    logic              fits;

    // shift in the next dividend bit and compare
    assign rem_sh = {rem_reg, sh_reg[Steps-1]};
    assign fits   = rem_sh >= {1'b0, den_reg};

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CntW'(Steps - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath: upper dividend bits are already below the divisor
    always_ff @(posedge aclk) begin
        if (start) begin
            den_reg <= den;
            rem_reg <= {1'b0, num[ProdW-1:Steps]};
            sh_reg  <= num[Steps-1:0];
        end else if (busy_reg) begin
            rem_reg <= fits ? DistW'(rem_sh - {1'b0, den_reg}) : rem_sh[DistW-1:0];
            sh_reg  <= {sh_reg[Steps-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = sh_reg[MagW-1:0];

endmodule

/* design/distance_weighted_drag_unit.sv */
// top level: point store, load and drag sequencer, shared arithmetic units
//
// Input stream: s_tuser carries the op (clear, load point, drag), s_tdata the
// x and y coordinates in signed Q16.16. s_tready is high while the sequencer
// is idle. A load measures the distance to the anchor with two serial
// squarings and a square root; loads beyond the store depth are dropped.
// A drag produces one result per stored point, in load order, with m_tlast
// on the final one; each point costs a memory read, two serial multiplies
// and two serial divides, with the multiplier and the divider each working
// one bit per cycle.
// A drag with an empty store or zero distance span produces nothing.
// Results leave through an output register: a new transaction is accepted
// while the last result waits, and when m_tready is low the sequencer holds
// the next finished result until the register frees.
// Reset empties the store, clears the anchor and mode registers and drops any
// pending result. The user writes configuration through cfg_we only while idle; the block does not enforce it.
module distance_weighted_drag_unit #(
    parameter int unsigned MAX_POINTS = dwd_pkg::MaxPointsDefault
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // input channel
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [63:0]                 s_tdata,  // x[31:0], y[63:32]
    input  logic [dwd_pkg::OpW-1:0]     s_tuser,  // op[1:0]
    // result channel
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [71:0]                 m_tdata,  // index[5:0], new_x[37:6], new_y[69:38], zero
    output logic                        m_tlast,
    // configuration write port
    input  logic                        cfg_we,
    input  logic [dwd_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [31:0]                 cfg_wdata
);
    import dwd_pkg::*;

    localparam int unsigned AddrW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int unsigned CntW  = $clog2(MAX_POINTS + 1);
    localparam int unsigned WordW = 2 * CoordW + DistW;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SQX, ST_SQY, ST_ROOT,
        ST_RD, ST_RDW, ST_MX, ST_DX, ST_MY, ST_DY, ST_EMIT
    } state_t;

    state_t                state_reg;
    logic                  far_mode_reg;
    logic signed [CoordW-1:0] anchor_x_reg, anchor_y_reg;
    logic [CntW-1:0]       count_reg;
    logic [DistW-1:0]      min_reg, max_reg, span_reg;
    logic [AddrW-1:0]      idx_reg;
    logic [CoordW-1:0]     ld_y_reg;
    logic [CoordW-1:0]     ld_x_reg;
    logic [ProdW-1:0]      sqx_reg;
    logic [MagW-1:0]       lx_reg, ly_reg;
    logic [DistW-1:0]      w_reg;
    logic [CoordW-1:0]     nx_reg;
    logic [CoordW-1:0]     ny_reg;
    logic                  m_tvalid_reg;
    logic [71:0]           m_tdata_reg;
    logic                  m_tlast_reg;

    logic [WordW-1:0]      mem [MAX_POINTS];
    logic [WordW-1:0]      rd_q_reg;

    logic                  s_acc, out_free, is_last;
    op_t                   op_in;
    logic [MagW-1:0]       in_dx, in_dy;
    logic [DistW:0]        diff;
    logic [DistW-1:0]      num_c, w_c;
    logic                  mul_start, mul_done, sqrt_start, sqrt_done, div_start, div_done;
    logic [MagW-1:0]       mul_a, mul_b, quot;
    logic [ProdW-1:0]      mul_prod, sqrt_op;
    logic [DistW-1:0]      root;
    logic [CoordW-1:0]     disp_c;
    logic [CoordW-1:0]     pt_x, pt_y;
    logic [DistW-1:0]      pt_d;

    // signed difference taken to magnitude
    function automatic logic [MagW-1:0] mag_of(input logic [MagW-1:0] v);
        return v[MagW-1] ? MagW'(-v) : v;
    endfunction

    // point plus or minus quotient, clamped to the 32-bit signed range
    function automatic logic [CoordW-1:0] move_sat(input logic [CoordW-1:0] p,
                                                   input logic neg,
                                                   input logic [MagW-1:0] q);
        logic [CoordW+1:0] s;
        s = neg ? {{2{p[CoordW-1]}}, p} - {1'b0, q} : {{2{p[CoordW-1]}}, p} + {1'b0, q};
        if (!s[CoordW+1] && s[CoordW:CoordW-1] != 2'b00) begin
            return {1'b0, {(CoordW-1){1'b1}}};
        end else if (s[CoordW+1] && s[CoordW:CoordW-1] != 2'b11) begin
            return {1'b1, {(CoordW-1){1'b0}}};
        end
        return s[CoordW-1:0];
    endfunction

    assign op_in    = op_t'(s_tuser);
    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign is_last  = (CntW'(idx_reg) + 1'b1) == count_reg;

    assign in_dx = mag_of(MagW'($signed(s_tdata[31:0])) - MagW'(anchor_x_reg));
    assign in_dy = mag_of(MagW'($signed(ld_y_reg)) - MagW'(anchor_y_reg));

    assign pt_x = rd_q_reg[CoordW-1:0];
    assign pt_y = rd_q_reg[2*CoordW-1:CoordW];
    assign pt_d = rd_q_reg[WordW-1:2*CoordW];

    // weight of the point being moved
    assign diff  = {1'b0, pt_d} - {1'b0, min_reg};
    assign num_c = (diff[DistW] || diff[DistW-1:0] > span_reg) ? span_reg : diff[DistW-1:0];
    assign w_c   = far_mode_reg ? num_c : span_reg - num_c;

    // unit start strobes and operands
    always_comb begin
        mul_start  = 1'b0;
        mul_a      = in_dx;
        mul_b      = in_dx;
        sqrt_start = (state_reg == ST_SQY) && mul_done;
        sqrt_op    = sqx_reg + mul_prod;
        div_start  = ((state_reg == ST_MX) || (state_reg == ST_MY)) && mul_done;
        case (state_reg)
            ST_IDLE: begin
                mul_start = s_acc && (op_in == OP_LOAD) && (count_reg < CntW'(MAX_POINTS));
            end
            ST_SQX: begin
                mul_start = mul_done;
                mul_a     = in_dy;
                mul_b     = in_dy;
            end
            ST_RDW: begin
                mul_start = 1'b1;
                mul_a     = mag_of(lx_reg);
                mul_b     = w_c;
            end
            ST_DX: begin
                mul_start = div_done;
                mul_a     = mag_of(ly_reg);
                mul_b     = w_reg;
            end
            default: begin
                mul_start = 1'b0;
            end
        endcase
    end

    assign disp_c = (state_reg == ST_DX) ? move_sat(pt_x, lx_reg[MagW-1], quot)
                                          : move_sat(pt_y, ly_reg[MagW-1], quot);

    dwd_mul u_mul (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (mul_start),
        .a      (mul_a),
        .b      (mul_b),
        .done   (mul_done),
        .prod   (mul_prod)
    );

    dwd_sqrt u_sqrt (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (sqrt_start),
        .operand(sqrt_op),
        .done   (sqrt_done),
        .root   (root)
    );

    dwd_div u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (div_start),
        .num    (mul_prod),
        .den    (span_reg),
        .done   (div_done),
        .quot   (quot)
    );

    // point store: written on load completion, read one point per drag step
    always_ff @(posedge aclk) begin
        if (state_reg == ST_ROOT && sqrt_done) begin
            mem[count_reg[AddrW-1:0]] <= {root, ld_y_reg, ld_x_reg};
        end
        if (state_reg == ST_RD) begin
            rd_q_reg <= mem[idx_reg];
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            far_mode_reg <= 1'b0;
            anchor_x_reg <= '0;
            anchor_y_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_FAR_MODE: far_mode_reg <= cfg_wdata[0];
                CFG_ANCHOR_X: anchor_x_reg <= cfg_wdata;
                CFG_ANCHOR_Y: anchor_y_reg <= cfg_wdata;
                default:      far_mode_reg <= far_mode_reg;
            endcase
        end
    end

    // working registers that need no reset
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            ld_x_reg <= s_tdata[31:0];
            ld_y_reg <= s_tdata[63:32];
            lx_reg   <= MagW'($signed(s_tdata[31:0])) - MagW'(anchor_x_reg);
            ly_reg   <= MagW'($signed(s_tdata[63:32])) - MagW'(anchor_y_reg);
            span_reg <= max_reg - min_reg;
        end
        if (state_reg == ST_SQX && mul_done) begin
            sqx_reg <= mul_prod;
        end
        if (state_reg == ST_RDW) begin
            w_reg <= w_c;
        end
        if (state_reg == ST_DX && div_done) begin
            nx_reg <= disp_c;
        end
        if (state_reg == ST_DY && div_done) begin
            ny_reg <= disp_c;
        end
    end

    // sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            min_reg      <= '1;
            max_reg      <= '0;
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            m_tlast_reg  <= 1'b0;
            m_tdata_reg  <= '0;
        end else begin
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_acc) begin
                        case (op_in)
                            OP_CLEAR: begin
                                count_reg <= '0;
                                min_reg   <= '1;
                                max_reg   <= '0;
                            end
                            OP_LOAD: begin
                                if (count_reg < CntW'(MAX_POINTS)) begin
                                    state_reg <= ST_SQX;
                                end
                            end
                            OP_DRAG: begin
                                idx_reg <= '0;
                                if (count_reg != '0 && max_reg > min_reg) begin
                                    state_reg <= ST_RD;
                                end
                            end
                            default: begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_SQX: if (mul_done) state_reg <= ST_SQY;
                ST_SQY: if (mul_done) state_reg <= ST_ROOT;
                ST_ROOT: begin
                    if (sqrt_done) begin
                        count_reg <= count_reg + 1'b1;
                        if (root < min_reg) min_reg <= root;
                        if (root > max_reg) max_reg <= root;
                        state_reg <= ST_IDLE;
                    end
                end
                ST_RD:  state_reg <= ST_RDW;
                ST_RDW: state_reg <= ST_MX;
                ST_MX:  if (mul_done) state_reg <= ST_DX;
                ST_DX:  if (div_done) state_reg <= ST_MY;
                ST_MY:  if (mul_done) state_reg <= ST_DY;
                ST_DY: begin
                    if (div_done) begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        m_tvalid_reg       <= 1'b1;
                        m_tlast_reg        <= is_last;
                        m_tdata_reg[5:0]   <= IndexW'(idx_reg);
                        m_tdata_reg[37:6]  <= nx_reg;
                        m_tdata_reg[69:38] <= ny_reg;
                        m_tdata_reg[71:70] <= 2'b00;
                        if (is_last) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= ST_RD;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

/* verif/distance_weighted_drag_unit_tb.sv */
// self-checking testbench for the distance weighted drag unit
`timescale 1ns / 1ps

module distance_weighted_drag_unit_tb;
    import dwd_pkg::*;

    localparam int unsigned Depth = 64;
    localparam int unsigned StallLimit = 20000;
    localparam int unsigned SettleCycles = 300;

    typedef struct packed {
        op_t         op;
        logic [31:0] x;
        logic [31:0] y;
    } cmd_t;

    typedef struct packed {
        logic [5:0]  index;
        logic [31:0] new_x;
        logic [31:0] new_y;
        logic        last;
    } moved_pt_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic        m_tlast;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_wdata;

    // shadow of the block's registers and point store
    logic        far_sel;
    logic [31:0] anchor_xr;
    logic [31:0] anchor_yr;
    logic [31:0] store_x [Depth];
    logic [31:0] store_y [Depth];
    logic [32:0] store_d [Depth];
    int          stored_n;
    logic [32:0] dist_lo;
    logic [32:0] dist_hi;

    cmd_t      cmd_q[$];
    moved_pt_t moved_q[$];

    int unsigned cycle_n;
    int unsigned quiet_from;
    int unsigned idle_n;
    int          mismatch_n;
    int          checked_n;
    int          loads_n;
    int          drags_n;
    int          sent_n;

    distance_weighted_drag_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // floor of the square root of a sum of two squares
    function automatic logic [32:0] euclid_dist(logic [31:0] px, logic [31:0] py);
        longint      dx;
        longint      dy;
        logic [67:0] sumsq;
        logic [67:0] trial;
        logic [33:0] root;
        logic [33:0] cand;
        dx = longint'($signed(px)) - longint'($signed(anchor_xr));
        dy = longint'($signed(py)) - longint'($signed(anchor_yr));
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        sumsq = 68'(dx) * 68'(dx) + 68'(dy) * 68'(dy);
        root = '0;
        for (int b = 33; b >= 0; b--) begin
            cand = root | (34'd1 << b);
            trial = 68'(cand) * 68'(cand);
            if (trial <= sumsq) root = cand;
        end
        return root[32:0];
    endfunction

    // point plus delta scaled by w / span, saturated to 32 bits
    function automatic logic [31:0] shift_coord(logic [31:0] p, longint delta,
                                                logic [32:0] w, logic [32:0] span);
        logic [127:0] prod;
        logic [127:0] q;
        longint       r;
        prod = 128'(delta < 0 ? -delta : delta) * 128'(w);
        q = prod / 128'(span);
        r = delta < 0 ? longint'($signed(p)) - longint'(q[63:0])
                      : longint'($signed(p)) + longint'(q[63:0]);
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r[31:0];
    endfunction

    // update the shadow store for one accepted command, queue drag results
    function automatic void apply_cmd(op_t op, logic [31:0] px, logic [31:0] py);
        logic [32:0] span;
        logic [32:0] num;
        logic [32:0] w;
        longint      lx;
        longint      ly;
        moved_pt_t   mp;
        case (op)
            OP_CLEAR: begin
                stored_n = 0;
                dist_lo = '1;
                dist_hi = '0;
            end
            OP_LOAD: begin
                loads_n++;
                if (stored_n < Depth) begin
                    store_x[stored_n] = px;
                    store_y[stored_n] = py;
                    store_d[stored_n] = euclid_dist(px, py);
                    if (store_d[stored_n] < dist_lo) dist_lo = store_d[stored_n];
                    if (store_d[stored_n] > dist_hi) dist_hi = store_d[stored_n];
                    stored_n++;
                end
            end
            OP_DRAG: begin
                drags_n++;
                if (stored_n != 0 && dist_hi > dist_lo) begin
                    span = dist_hi - dist_lo;
                    lx = longint'($signed(px)) - longint'($signed(anchor_xr));
                    ly = longint'($signed(py)) - longint'($signed(anchor_yr));
                    for (int i = 0; i < stored_n; i++) begin
                        num = store_d[i] - dist_lo;
                        if (num > span) num = span;
                        w = far_sel ? num : span - num;
                        mp.index = i[5:0];
                        mp.new_x = shift_coord(store_x[i], lx, w, span);
                        mp.new_y = shift_coord(store_y[i], ly, w, span);
                        mp.last = (i + 1 == stored_n);
                        moved_q.push_back(mp);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // random gaps, except in one long quiet stretch
    function automatic bit idle_now();
        if (cycle_n >= quiet_from && cycle_n < quiet_from + 30000) return 1'b0;
        return $urandom_range(99) < 8;
    endfunction

    // input driver: predicts on each accepted transaction, then offers the next
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= OP_NONE;
        end else begin
            if (s_tvalid && s_tready)
                apply_cmd(op_t'(s_tuser), s_tdata[31:0], s_tdata[63:32]);
            if (!s_tvalid || s_tready) begin
                if (cmd_q.size() != 0 && !idle_now()) begin
                    cmd_t c;
                    c = cmd_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= c.op;
                    s_tdata <= {c.y, c.x};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor and checker
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= !idle_now();
            if (m_tvalid && m_tready) begin
                moved_pt_t want;
                moved_pt_t got;
                got = {m_tdata[5:0], m_tdata[37:6], m_tdata[69:38], m_tlast};
                checked_n++;
                if (moved_q.size() == 0) begin
                    mismatch_n++;
                    if (mismatch_n <= 10)
                        $display("unexpected result: idx %0d x %h y %h last %b",
                                 got.index, got.new_x, got.new_y, got.last);
                end else begin
                    want = moved_q.pop_front();
                    if (got !== want) begin
                        mismatch_n++;
                        if (mismatch_n <= 10)
                            $display({"mismatch: exp idx %0d x %h y %h last %b, ",
                                      "got idx %0d x %h y %h last %b"},
                                     want.index, want.new_x, want.new_y, want.last,
                                     got.index, got.new_x, got.new_y, got.last);
                    end
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        cycle_n <= cycle_n + 1;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_n <= 0;
        end else if (idle_n >= StallLimit) begin
            $display("distance_weighted_drag_unit_tb failed");
            $finish;
        end else begin
            idle_n <= idle_n + 1;
        end
    end

    task automatic send(op_t op, logic [31:0] px, logic [31:0] py);
        cmd_t c;
        c.op = op;
        c.x = px;
        c.y = py;
        cmd_q.push_back(c);
        sent_n++;
    endtask

    // block idle: all commands taken, all results seen, processing drained
    task automatic wait_idle();
        while (cmd_q.size() != 0 || s_tvalid || moved_q.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_FAR_MODE: far_sel = val[0];
            CFG_ANCHOR_X: anchor_xr = val;
            CFG_ANCHOR_Y: anchor_yr = val;
            default: ;
        endcase
    endtask

    // coordinate mix: full range, near the anchor, or an extreme
    function automatic logic [31:0] pick_coord(logic [31:0] base);
        case ($urandom_range(9))
            0, 1, 2: return $urandom();
            3:       return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return base + 32'($signed($urandom_range(200000)) - 100000) * 16;
        endcase
    endfunction

    initial begin
        int n;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_FAR_MODE;
        cfg_wdata = '0;
        m_tready = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_NONE;
        cycle_n = 0;
        idle_n = 0;
        quiet_from = $urandom_range(30000, 60000);
        far_sel = 1'b0;
        anchor_xr = '0;
        anchor_yr = '0;
        stored_n = 0;
        dist_lo = '1;
        dist_hi = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty store, single point, unused op, near mode
        send(OP_DRAG, 32'h0001_0000, 32'h0002_0000);
        send(OP_LOAD, 32'h0003_0000, 32'h0004_0000);
        send(OP_DRAG, 32'h0001_0000, 32'h0001_0000);
        send(OP_NONE, 32'hffff_ffff, 32'hffff_ffff);
        send(OP_LOAD, 32'h0000_0000, 32'h0001_0000);
        send(OP_LOAD, 32'hfffa_0000, 32'h0008_0000);
        send(OP_DRAG, 32'h0010_0000, 32'hfff0_0000);
        wait_idle();

        // extremes against an opposite anchor, far mode, saturation
        write_reg(CFG_FAR_MODE, 32'd1);
        write_reg(CFG_ANCHOR_X, 32'h8000_0000);
        write_reg(CFG_ANCHOR_Y, 32'h7fff_ffff);
        send(OP_CLEAR, 32'h0, 32'h0);
        send(OP_LOAD, 32'h7fff_ffff, 32'h8000_0000);
        send(OP_LOAD, 32'h8000_0000, 32'h7fff_ffff);
        send(OP_LOAD, 32'h0000_0000, 32'h0000_0000);
        send(OP_DRAG, 32'h7fff_ffff, 32'h8000_0000);
        send(OP_DRAG, 32'h8000_0000, 32'h7fff_ffff);
        wait_idle();

        // anchor moved after loads keeps stored distances
        write_reg(CFG_ANCHOR_X, 32'h0005_0000);
        write_reg(CFG_ANCHOR_Y, 32'hfffb_0000);
        write_reg(CFG_FAR_MODE, 32'd0);
        send(OP_DRAG, 32'h0000_8000, 32'h7fff_0000);
        send(OP_CLEAR, 32'h0, 32'h0);
        send(OP_DRAG, 32'h0001_0000, 32'h0001_0000);

        // random phases of well-formed load and drag sequences
        while (sent_n < 290) begin
            wait_idle();
            write_reg(CFG_FAR_MODE, $urandom_range(1));
            if ($urandom_range(3) != 0)
                write_reg(CFG_ANCHOR_X, $urandom_range(4) == 0 ? $urandom() : pick_coord(0));
            if ($urandom_range(3) != 0)
                write_reg(CFG_ANCHOR_Y, $urandom_range(4) == 0 ? $urandom() : pick_coord(0));
            if ($urandom_range(3) != 0) send(OP_CLEAR, $urandom(), $urandom());
            // one full store per run, beyond capacity
            n = (sent_n > 150 && loads_n < 150) ? 68 : $urandom_range(1, 8);
            if (n == 68) loads_n = 1000;
            for (int i = 0; i < n; i++) begin
                send(OP_LOAD, pick_coord(anchor_xr), pick_coord(anchor_yr));
                if ($urandom_range(19) == 0) send(OP_NONE, $urandom(), $urandom());
            end
            for (int i = $urandom_range(1, n == 68 ? 1 : 4); i > 0; i--)
                send(OP_DRAG, pick_coord(anchor_xr), pick_coord(anchor_yr));
        end

        wait_idle();
        repeat (SettleCycles) @(posedge aclk);
        $display("covered %0d commands with %0d drags, %0d moved points checked",
                 sent_n, drags_n, checked_n);
        if (mismatch_n == 0 && moved_q.size() == 0)
            $display("distance_weighted_drag_unit_tb passed");
        else
            $display("distance_weighted_drag_unit_tb failed");
        $finish;
    end

endmodule
